### rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ASSERT_SAME_CYCLE(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("same-cycle check failed");

// property that must hold in the cycle after its trigger
`define ASSERT_NEXT_CYCLE(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

### rtl/jep_pkg.sv
// shared types, constants and helpers of the julia escape pixel block
`timescale 1ns / 1ps

package jep_pkg;

  localparam int IDX_W    = 9;
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 28;
  localparam int LIMIT_W  = 8;
  localparam int PROD_W   = 2 * Q_W;
  localparam int WIDE_W   = 40;
  // start point is index * 2^(FRAC_W+2) / RES
  localparam int DIV_W    = IDX_W + FRAC_W + 2;
  // |z|^2 >= 4 in Q8.56
  localparam int MAG_BIT  = 2 * FRAC_W + 2;

  localparam int RES_DEFAULT = 512;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;

  localparam logic signed [Q_W-1:0] C_REAL_RST = 32'sd240553682;
  localparam logic signed [Q_W-1:0] C_IMAG_RST = -32'sd479960823;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST  = 8'd99;

  localparam logic signed [Q_W-1:0]    Q_MAX     = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0]    Q_MIN     = 32'sh8000_0000;
  localparam logic signed [WIDE_W-1:0] Q_MAX_W   = 40'sd2147483647;
  localparam logic signed [WIDE_W-1:0] Q_MIN_W   = -40'sd2147483648;
  // -2.0 offset of the start mapping, as 2^29
  localparam logic signed [WIDE_W-1:0] START_OFS = 40'sd536870912;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
  } iter_ctl_t;

  // clamp a wide signed value to the Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX_W) begin
      r = Q_MAX;
    end else if (v < Q_MIN_W) begin
      r = Q_MIN;
    end else begin
      r = $signed(v[Q_W-1:0]);
    end
    return r;
  endfunction

endpackage

### rtl/jep_if.sv
// valid/ready channels for pixel coordinates and escape results
`timescale 1ns / 1ps

interface jep_pix_if;
  logic                       valid;
  logic                       ready;
  logic [jep_pkg::IDX_W-1:0]  column;
  logic [jep_pkg::IDX_W-1:0]  row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface jep_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

### rtl/julia_escape_pixel.sv
// top level of the julia set escape-time pixel test
`timescale 1ns / 1ps

// One pixel (column, row) is taken per transfer and one bit comes back: inside_res is 1
// when z = z*z + c, started at index*4/RES - 2 on each axis in signed Q4.28, never reaches
// |z|^2 >= 4 within iteration_limit updates, and 0 as soon as one update does. The start
// point is not tested, and a limit of zero returns 1. The start point, index * 2^30 / RES,
// comes from constant multiplications and is registered at the transfer edge; the next
// cycle loads it into a single unit of three 32x32 multipliers, which runs each update in
// the states S_MUL, for the registered products, and S_UPD, for the add, clamp and escape
// compare. A pixel passes S_MAP, then S_MUL and S_UPD once per update, then S_FINISH,
// where it waits while the previous result still sits unclaimed. One pixel is worked on
// at a time; the finished bit waits in an output register, so the next pixel can transfer
// in the same cycle that the result is presented, while that result is still unclaimed.
// Configuration writes are taken whenever cfg_we is high and must only come while idle.

module julia_escape_pixel #(
  parameter int RES = jep_pkg::RES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [jep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jep_pkg::Q_W-1:0]           cfg_data,
  jep_pix_if.sink                           pixel,
  jep_res_if.source                         result
);

  localparam int LW = jep_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MUL,
    S_UPD,
    S_FINISH
  } state_t;

  state_t                           state;
  logic signed [jep_pkg::Q_W-1:0]   c_real;
  logic signed [jep_pkg::Q_W-1:0]   c_imag;
  logic [jep_pkg::LIMIT_W-1:0]      iter_limit;
  logic [jep_pkg::LIMIT_W-1:0]      count;
  logic                             verdict;
  logic                             out_valid;
  logic                             out_inside;

  logic                             pix_xfer;
  logic                             map_done;
  logic signed [jep_pkg::Q_W-1:0]   zx_start, zy_start;
  logic                             escaped;
  logic                             escape_now;
  logic                             at_limit;
  jep_pkg::iter_ctl_t               ctl;

  // configuration registers, writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real     <= jep_pkg::C_REAL_RST;
      c_imag     <= jep_pkg::C_IMAG_RST;
      iter_limit <= jep_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jep_pkg::CFG_C_REAL:     c_real     <= $signed(cfg_data);
        jep_pkg::CFG_C_IMAG:     c_imag     <= $signed(cfg_data);
        jep_pkg::CFG_ITER_LIMIT: iter_limit <= cfg_data[jep_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pixel.ready = (state == S_IDLE);
  assign pix_xfer    = pixel.valid && pixel.ready;

  // start point mapping for both axes
  jep_map #(
    .RES (RES)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .start    (pix_xfer),
    .column   (pixel.column),
    .row      (pixel.row),
    .done     (map_done),
    .zx_start (zx_start),
    .zy_start (zy_start)
  );

  // the start point is skipped by the escape test, hence count != 0
  assign escape_now = (count != '0) && escaped;
  assign at_limit   = (count == iter_limit);

  always_comb begin
    ctl.load = (state == S_MAP) && map_done;
    ctl.mul  = (state == S_MUL);
    ctl.upd  = (state == S_UPD) && !escape_now && !at_limit;
  end

  // shared multiply / update unit
  jep_iter u_iter (
    .clk      (clk),
    .ctl      (ctl),
    .zx_start (zx_start),
    .zy_start (zy_start),
    .c_real   (c_real),
    .c_imag   (c_imag),
    .escaped  (escaped)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      verdict   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // load the output register when free, else clear it once taken
      if (state == S_FINISH && (!out_valid || result.ready)) begin
        out_valid  <= 1'b1;
        out_inside <= verdict;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pix_xfer) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (map_done) begin
            count <= '0;
            if (iter_limit == '0) begin
              verdict <= 1'b1;
              state   <= S_FINISH;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (escape_now) begin
            verdict <= 1'b0;
            state   <= S_FINISH;
          end else if (at_limit) begin
            verdict <= 1'b1;
            state   <= S_FINISH;
          end else begin
            count <= count + LW'(1);
            state <= S_MUL;
          end
        end
        S_FINISH: begin
          // wait for the output register to free up
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.inside_res = out_inside;

endmodule

### rtl/jep_map.sv
// start point mapping: index * 2^30 / RES by constant multiplication, both axes
`timescale 1ns / 1ps

module jep_map #(
  parameter int RES = jep_pkg::RES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [jep_pkg::IDX_W-1:0]         column,
  input  logic [jep_pkg::IDX_W-1:0]         row,
  output logic                              done,
  output logic signed [jep_pkg::Q_W-1:0]    zx_start,
  output logic signed [jep_pkg::Q_W-1:0]    zy_start
);

  // index * 2^30 / RES = index * Q_WHOLE + index * Q_FRAC / RES, the second term
  // taken with a rounded-up reciprocal, exact while index * RES < 2^SH
  localparam int DW     = jep_pkg::DIV_W;
  localparam int SH     = jep_pkg::IDX_W + $clog2(RES);
  localparam int PART_W = jep_pkg::IDX_W + SH;
  localparam longint unsigned SCALE   = 64'd1 << (jep_pkg::FRAC_W + 2);
  localparam longint unsigned Q_WHOLE = SCALE / RES;
  localparam longint unsigned Q_FRAC  = SCALE % RES;
  localparam longint unsigned RECIP   = (Q_FRAC * (64'd1 << SH) + RES - 1) / RES;
  localparam logic [DW-1:0] WHOLE_V = DW'(Q_WHOLE);
  localparam logic [SH-1:0] RECIP_V = SH'(RECIP);

  logic [DW-1:0] quo_q [2];

  function automatic logic [DW-1:0] scale_idx(input logic [jep_pkg::IDX_W-1:0] idx);
    logic [PART_W-1:0] part;
    part = PART_W'(idx) * PART_W'(RECIP_V);
    return DW'(idx) * WHOLE_V + DW'(part[PART_W-1:SH]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_q[0] <= scale_idx(column);
      quo_q[1] <= scale_idx(row);
    end
  end

  // subtract 2.0 and clamp
  assign zx_start = jep_pkg::sat_q($signed({1'b0, quo_q[0]}) - jep_pkg::START_OFS);
  assign zy_start = jep_pkg::sat_q($signed({1'b0, quo_q[1]}) - jep_pkg::START_OFS);

endmodule

### rtl/jep_iter.sv
// shared complex square-and-add unit with the escape compare
`timescale 1ns / 1ps

module jep_iter (
  input  logic                            clk,
  input  jep_pkg::iter_ctl_t              ctl,
  input  logic signed [jep_pkg::Q_W-1:0]  zx_start,
  input  logic signed [jep_pkg::Q_W-1:0]  zy_start,
  input  logic signed [jep_pkg::Q_W-1:0]  c_real,
  input  logic signed [jep_pkg::Q_W-1:0]  c_imag,
  output logic                            escaped
);

  localparam int PW = jep_pkg::PROD_W;
  localparam int WW = jep_pkg::WIDE_W;
  localparam int FW = jep_pkg::FRAC_W;

  logic signed [jep_pkg::Q_W-1:0] zx, zy;
  logic signed [jep_pkg::Q_W-1:0] nx, ny;
  logic signed [PW-1:0]           xx, yy, xy;
  logic signed [PW-1:0]           diff;
  logic [PW-1:0]                  mag;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      zx <= zx_start;
      zy <= zy_start;
    end else if (ctl.upd) begin
      zx <= nx;
      zy <= ny;
    end
    if (ctl.mul) begin
      xx <= PW'(zx) * PW'(zx);
      yy <= PW'(zy) * PW'(zy);
      xy <= PW'(zx) * PW'(zy);
    end
  end

  // floor shifts are plain slices of the signed products
  always_comb begin
    diff = xx - yy;
    nx   = jep_pkg::sat_q(WW'($signed(diff[PW-1:FW])) + WW'(c_real));
    ny   = jep_pkg::sat_q(WW'($signed(xy[PW-1:FW-1])) + WW'(c_imag));
    mag  = $unsigned(xx) + $unsigned(yy);
  end

  assign escaped = |mag[PW-1:jep_pkg::MAG_BIT];

endmodule

### rtl/jep_checker.sv
// port-level checks of the julia escape pixel block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jep_checker (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_inside
);

  // a result waits until it is taken
  `ASSERT_NEXT_CYCLE(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  // a waiting result keeps its value
  `ASSERT_NEXT_CYCLE(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_inside))

  // one pixel at a time: no second transfer right after a transfer
  `ASSERT_NEXT_CYCLE(a_one_item, clk, rst, pix_valid && pix_ready, !pix_ready)

  // a result never appears in the cycle right after a pixel transfer
  `ASSERT_NEXT_CYCLE(a_no_instant, clk, rst, pix_valid && pix_ready, !$rose(res_valid))

endmodule

bind julia_escape_pixel jep_checker u_jep_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pixel.valid),
  .pix_ready  (pixel.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_inside (result.inside_res)
);

### tb/sv/julia_escape_pixel_checker.sv
// checker that predicts and compares the escape bit of every pixel transfer
`timescale 1ns / 1ps

module julia_escape_pixel_checker #(
  parameter int RES = jep_pkg::RES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jep_pkg::Q_W-1:0]       cfg_data,
  jep_pix_if                            pixel,
  jep_res_if                            result,
  output int                            errors,
  output int                            pending
);
  import jep_pkg::*;

  // 4.0 in the Q8.56 square domain
  localparam longint unsigned ESCAPE_MAG = 64'd1 << MAG_BIT;

  typedef struct {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
    logic             in_set;
  } pixel_verdict_t;

  logic signed [Q_W-1:0] c_re;
  logic signed [Q_W-1:0] c_im;
  logic [LIMIT_W-1:0]    iter_lim;
  pixel_verdict_t        verdict_q[$];
  pixel_verdict_t        oldest;
  pixel_verdict_t        fresh;
  int                    err_cnt = 0;

  function automatic longint clamp_q(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  // index * 4 / RES - 2, floored
  function automatic longint start_point(input logic [IDX_W-1:0] idx);
    return clamp_q(longint'(idx) * (64'sd1 <<< (FRAC_W + 2)) / RES
                   - (64'sd1 <<< (FRAC_W + 1)));
  endfunction

  function automatic logic predict_inside(input logic [IDX_W-1:0] col,
                                          input logic [IDX_W-1:0] rw);
    longint          zx;
    longint          zy;
    longint          nx;
    longint          ny;
    longint unsigned mag;
    zx = start_point(col);
    zy = start_point(rw);
    for (int n = 0; n < int'(iter_lim); n++) begin
      nx = clamp_q(((zx * zx - zy * zy) >>> FRAC_W) + longint'(c_re));
      ny = clamp_q(((zx * zy) >>> (FRAC_W - 1)) + longint'(c_im));
      zx = nx;
      zy = ny;
      mag = $unsigned(zx * zx) + $unsigned(zy * zy);
      if (mag >= ESCAPE_MAG) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      c_re     = C_REAL_RST;
      c_im     = C_IMAG_RST;
      iter_lim = LIMIT_RST;
      verdict_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result transfer with nothing pending: expected none, actual %0b",
                   $time, result.inside_res);
          err_cnt++;
        end else begin
          oldest = verdict_q.pop_front();
          if (result.inside_res !== oldest.in_set) begin
            $display("%0t: inside_res of pixel (%0d,%0d): expected %0b, actual %0b",
                     $time, oldest.column, oldest.row, oldest.in_set, result.inside_res);
            err_cnt++;
          end
        end
      end
      if (pixel.valid && pixel.ready) begin
        fresh.column = pixel.column;
        fresh.row    = pixel.row;
        fresh.in_set = predict_inside(pixel.column, pixel.row);
        verdict_q.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_C_REAL:     c_re     = cfg_data;
          CFG_C_IMAG:     c_im     = cfg_data;
          CFG_ITER_LIMIT: iter_lim = cfg_data[LIMIT_W-1:0];
          default:        ;
        endcase
      end
    end
    errors  <= err_cnt;
    pending <= verdict_q.size();
  end

endmodule

### tb/sv/julia_escape_pixel_tb.sv
// testbench top of the julia escape pixel block: stimulus, config phases and verdict
`timescale 1ns / 1ps

module julia_escape_pixel_tb;
  import jep_pkg::*;

  // generous bound: every pixel at the largest limit plus gaps and stalls, several times
  localparam int CYCLE_LIMIT = 4_000_000;
  // one full pixel at limit 255 with margin
  localparam int TAIL_CYCLES = 2 * 255 + 40;

  // roughly -0.8 + 0.156i, a connected julia set with deep orbits
  localparam logic signed [Q_W-1:0] C_DEEP_RE = -32'sd214748365;
  localparam logic signed [Q_W-1:0] C_DEEP_IM = 32'sd41875931;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0]       cfg_data;
  // high during the stretch with no idling on either side
  logic                 steady;
  int                   errors;
  int                   pending;

  jep_pix_if pix_ch ();
  jep_res_if res_ch ();

  julia_escape_pixel #(
    .RES(RES_DEFAULT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pix_ch),
    .result(res_ch)
  );

  julia_escape_pixel_checker #(
    .RES(RES_DEFAULT)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pix_ch),
    .result(res_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: ready drops in about a fifth of the cycles unless steady
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("julia_escape_pixel_tb: done, errors");
    $finish;
  end

  // half the coordinates are drawn from the middle of the plane where the set lives
  function automatic logic [IDX_W-1:0] rand_coord();
    if ($urandom_range(1) == 0) return IDX_W'($urandom_range(511));
    return IDX_W'($urandom_range(383, 128));
  endfunction

  // constant of magnitude at most 1.0 on each axis
  function automatic logic signed [Q_W-1:0] rand_small_c();
    int v;
    v = int'($urandom_range(32'd536870912)) - 268435456;
    return v;
  endfunction

  // one pixel transfer; valid is only lowered when a gap really follows, so it is
  // never dropped and raised in the same step
  task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] rw);
    int gap;
    gap = 0;
    if (!steady) begin
      // mostly short gaps, now and then a long one that lands inside the iteration
      if ($urandom_range(9) == 0) begin
        gap = $urandom_range(300);
      end else begin
        while ($urandom_range(99) < 20) gap++;
      end
    end
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid  <= 1'b1;
    pix_ch.column <= col;
    pix_ch.row    <= rw;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_pixel(rand_coord(), rand_coord());
  endtask

  // wait until every predicted bit has come back; pending is a registered copy, so
  // the loop steps the clock before looking at it
  task automatic drain();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // back-to-back writes of all three registers, enable held high throughout
  task automatic set_config(input logic signed [Q_W-1:0] cr,
                            input logic signed [Q_W-1:0] ci,
                            input logic [LIMIT_W-1:0]    lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_C_REAL;
    cfg_data  <= cr;
    @(posedge clk);
    cfg_index <= CFG_C_IMAG;
    cfg_data  <= ci;
    @(posedge clk);
    cfg_index <= CFG_ITER_LIMIT;
    cfg_data  <= {{(Q_W - LIMIT_W){1'b0}}, lim};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_C_REAL;
    cfg_data      = '0;
    steady        = 1'b0;
    pix_ch.valid  = 1'b0;
    pix_ch.column = '0;
    pix_ch.row    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset constants: corners of the plane, the origin, a point near it and two more points
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd255, 9'd255);
    send_pixel(9'd256, 9'd0);
    send_pixel(9'd170, 9'd300);
    drain();

    // a single update per pixel
    set_config(C_REAL_RST, C_IMAG_RST, 8'd1);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd384, 9'd256);
    drain();

    // zero limit: no update runs, every pixel reads inside
    set_config(C_REAL_RST, C_IMAG_RST, 8'd0);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd256, 9'd256);
    drain();

    // extreme constants: the real sum clamps high, then low
    set_config(Q_MAX, Q_MIN, 8'd255);
    send_pixel(9'd511, 9'd256);
    send_pixel(9'd256, 9'd256);
    drain();
    set_config(Q_MIN, Q_MAX, 8'd2);
    send_pixel(9'd256, 9'd0);
    send_pixel(9'd0, 9'd511);
    drain();

    // c = 0 at the largest limit: 0 and 1 are fixed points, the corner runs away
    set_config('0, '0, 8'd255);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd384, 9'd256);
    send_pixel(9'd0, 9'd0);
    drain();

    // random pixels, back at the reset constants
    set_config(C_REAL_RST, C_IMAG_RST, LIMIT_RST);
    run_random(350);
    drain();

    // long stretch with no idling on either side
    steady <= 1'b1;
    set_config(rand_small_c(), rand_small_c(), LIMIT_W'($urandom_range(64, 1)));
    run_random(300);
    drain();
    steady <= 1'b0;

    // deep orbits at the largest limit
    set_config(C_DEEP_RE, C_DEEP_IM, 8'd255);
    run_random(150);
    drain();

    // any 32-bit constant, clamping happens often
    repeat (4) begin
      set_config($urandom, $urandom, LIMIT_W'($urandom_range(255, 1)));
      run_random(50);
      drain();
    end

    // one update with random constants
    set_config(rand_small_c(), rand_small_c(), 8'd1);
    run_random(150);
    drain();

    // random constants of moderate size, small to mid limits
    repeat (8) begin
      set_config(rand_small_c(), rand_small_c(), LIMIT_W'($urandom_range(128, 1)));
      run_random(50);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("julia_escape_pixel_tb: done, clean");
    end else begin
      $display("julia_escape_pixel_tb: done, errors");
    end
    $finish;
  end

endmodule
